/* hw/rtl/hill_cipher_2x2_mod26_top_assert.svh */
// Assertion macros for the Hill cipher pair pipeline.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef HILL_CIPHER_2X2_MOD26_TOP_ASSERT_SVH
`define HILL_CIPHER_2X2_MOD26_TOP_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define HC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hill cipher check failed in the same cycle");

// Consequence must hold in the cycle after the antecedent.
`define HC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hill cipher check failed one cycle later");

`endif

/* hw/rtl/hc_pkg.sv */
// Shared types, constants and modulo-26 helpers for the Hill cipher block.
// No dependencies; used by the channel interfaces and the top level.
package hc_pkg;

  localparam int LETTER_W = 5;
  localparam int PROD_W   = 10;
  localparam int SUM_W    = 11;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [SUM_W-1:0]    sum_t;

  localparam letter_t MODULUS = 5'd26;

  // Mode codes on the input beat.
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_KEY_TOP_LEFT     = 2'd0,
    CFG_KEY_TOP_RIGHT    = 2'd1,
    CFG_KEY_BOTTOM_LEFT  = 2'd2,
    CFG_KEY_BOTTOM_RIGHT = 2'd3
  } cfg_idx_t;

  // Inverse modulo 26 of each residue; zero where none exists.
  localparam letter_t INV_TABLE [0:25] = '{
    5'd0, 5'd1, 5'd0, 5'd9, 5'd0, 5'd21, 5'd0, 5'd15, 5'd0, 5'd3, 5'd0, 5'd19, 5'd0,
    5'd0, 5'd0, 5'd7, 5'd0, 5'd23, 5'd0, 5'd11, 5'd0, 5'd5, 5'd0, 5'd17, 5'd0, 5'd25
  };

  // Fold a raw 5-bit value into 0..25.
  function automatic letter_t red26(input letter_t x);
    red26 = (x >= MODULUS) ? letter_t'(x - MODULUS) : x;
  endfunction

  // Residue modulo 26 of an 11-bit value. The quotient estimate x*39/1024
  // is exact or one low over the whole range, so one correction is enough.
  function automatic letter_t mod26(input sum_t x);
    logic [16:0] qprod;
    logic [6:0]  q;
    sum_t        r;
    qprod = 17'(x) * 17'd39;
    q     = qprod[16:10];
    r     = sum_t'(x - sum_t'(sum_t'(q) * sum_t'(MODULUS)));
    if (r >= sum_t'(MODULUS)) begin
      r = sum_t'(r - sum_t'(MODULUS));
    end
    mod26 = r[LETTER_W-1:0];
  endfunction

  // Additive inverse modulo 26 of a residue.
  function automatic letter_t neg26(input letter_t x);
    neg26 = (x == '0) ? '0 : letter_t'(MODULUS - x);
  endfunction

  // 5 by 5 product widened to the product width.
  function automatic prod_t mul5(input letter_t x, input letter_t y);
    mul5 = prod_t'(x) * prod_t'(y);
  endfunction

endpackage

/* hw/rtl/hc_in_if.sv */
// Input channel of the Hill cipher block: one letter pair and a mode per beat.
// Depends on hc_pkg for the letter type.
interface hc_in_if;
  logic            valid;
  logic            ready;
  logic            mode;
  hc_pkg::letter_t letter_first;
  hc_pkg::letter_t letter_second;

  modport source (output valid, output mode, output letter_first, output letter_second,
                  input ready);
  modport sink   (input valid, input mode, input letter_first, input letter_second,
                  output ready);
endinterface

/* hw/rtl/hc_out_if.sv */
// Result channel of the Hill cipher block: one letter pair and a flag per beat.
// Depends on hc_pkg for the letter type.
interface hc_out_if;
  logic            valid;
  logic            ready;
  hc_pkg::letter_t out_first;
  hc_pkg::letter_t out_second;
  logic            key_not_invertible;

  modport source (output valid, output out_first, output out_second,
                  output key_not_invertible, input ready);
  modport sink   (input valid, input out_first, input out_second,
                  input key_not_invertible, output ready);
endinterface

/* hw/rtl/hill_cipher_2x2_mod26_top.sv */
// Hill cipher 2x2 modulo 26, five-stage pipeline.
// Throughput: one pair per cycle while the result channel is not stalled;
// each stage holds one beat and each stage multiplier or modulo-26 reducer
// is used once per beat.
// Reset (synchronous, rst_n low) clears the key registers to zero, empties
// every pipeline stage and holds the input ready low.
module hill_cipher_2x2_mod26_top (
  input  logic              clk,
  input  logic              rst_n,
  hc_in_if.sink             in_chan,
  hc_out_if.source          out_chan,
  input  logic              cfg_we,
  input  hc_pkg::cfg_idx_t  cfg_index,
  input  hc_pkg::letter_t   cfg_wdata
);
  import hc_pkg::*;

  // Key registers.
  letter_t key_tl_r, key_tr_r, key_bl_r, key_br_r;
  letter_t ka, kb, kc, kd;

  // Stage valids and per-stage ready.
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  // Stage A: reduced letters and determinant products.
  logic    mode_a_r;
  letter_t p0_a_r, p1_a_r;
  prod_t   ad_a_r, bc_a_r;
  // Stage B: determinant inverse and flag.
  logic    mode_b_r, flag_b_r;
  letter_t p0_b_r, p1_b_r, inv_b_r;
  letter_t det_nxt, inv_nxt;
  logic [LETTER_W:0] det_sum;
  // Stage C: selected matrix.
  logic    mode_c_r, flag_c_r;
  letter_t p0_c_r, p1_c_r;
  letter_t m00_c_r, m01_c_r, m10_c_r, m11_c_r;
  // Stage D: matrix by vector products.
  logic    mode_d_r, flag_d_r;
  prod_t   pr00_d_r, pr01_d_r, pr10_d_r, pr11_d_r;
  // Stage E: reduced result.
  logic    mode_e_r, flag_e_r;
  letter_t r0_e_r, r1_e_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_tl_r <= '0;
      key_tr_r <= '0;
      key_bl_r <= '0;
      key_br_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_TOP_LEFT:     key_tl_r <= cfg_wdata;
        CFG_KEY_TOP_RIGHT:    key_tr_r <= cfg_wdata;
        CFG_KEY_BOTTOM_LEFT:  key_bl_r <= cfg_wdata;
        CFG_KEY_BOTTOM_RIGHT: key_br_r <= cfg_wdata;
        default:              key_tl_r <= key_tl_r;
      endcase
    end
  end

  // Key residues; the user must keep the key stable while beats are in flight (not enforced here).
  assign ka = red26(key_tl_r);
  assign kb = red26(key_tr_r);
  assign kc = red26(key_bl_r);
  assign kd = red26(key_br_r);

  // A stage may load when it is empty or its contents move on.
  // The input is refused while reset is asserted.
  assign rdy_e = !v_e_r || out_chan.ready;
  assign rdy_d = !v_d_r || rdy_e;
  assign rdy_c = !v_c_r || rdy_d;
  assign rdy_b = !v_b_r || rdy_c;
  assign rdy_a = !v_a_r || rdy_b;
  assign in_chan.ready = rdy_a && rst_n;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
    end else begin
      if (rdy_a) v_a_r <= in_chan.valid;
      if (rdy_b) v_b_r <= v_a_r;
      if (rdy_c) v_c_r <= v_b_r;
      if (rdy_d) v_d_r <= v_c_r;
      if (rdy_e) v_e_r <= v_d_r;
    end
  end

  // Stage A: fold the letters and form the two determinant products.
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      mode_a_r <= in_chan.mode;
      p0_a_r   <= red26(in_chan.letter_first);
      p1_a_r   <= red26(in_chan.letter_second);
      ad_a_r   <= mul5(ka, kd);
      bc_a_r   <= mul5(kb, kc);
    end
  end

  // Stage B logic: determinant as a true residue, then its inverse.
  always_comb begin
    det_sum = (LETTER_W+1)'(mod26(sum_t'(ad_a_r))) +
              (LETTER_W+1)'(neg26(mod26(sum_t'(bc_a_r))));
    if (det_sum >= (LETTER_W+1)'(MODULUS)) begin
      det_sum = (LETTER_W+1)'(det_sum - (LETTER_W+1)'(MODULUS));
    end
    det_nxt = det_sum[LETTER_W-1:0];
    inv_nxt = INV_TABLE[det_nxt];
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      mode_b_r <= mode_a_r;
      p0_b_r   <= p0_a_r;
      p1_b_r   <= p1_a_r;
      inv_b_r  <= inv_nxt;
      flag_b_r <= (mode_a_r == MODE_DECRYPT) && (inv_nxt == '0);
    end
  end

  // Stage C: pick the key for encryption or the adjugate times the inverse.
  always_ff @(posedge clk) begin
    if (rdy_c) begin
      mode_c_r <= mode_b_r;
      flag_c_r <= flag_b_r;
      p0_c_r   <= p0_b_r;
      p1_c_r   <= p1_b_r;
      if (mode_b_r == MODE_DECRYPT) begin
        m00_c_r <= mod26(sum_t'(mul5(kd, inv_b_r)));
        m01_c_r <= mod26(sum_t'(mul5(neg26(kb), inv_b_r)));
        m10_c_r <= mod26(sum_t'(mul5(neg26(kc), inv_b_r)));
        m11_c_r <= mod26(sum_t'(mul5(ka, inv_b_r)));
      end else begin
        m00_c_r <= ka;
        m01_c_r <= kb;
        m10_c_r <= kc;
        m11_c_r <= kd;
      end
    end
  end

  // Stage D: the four matrix by vector products.
  always_ff @(posedge clk) begin
    if (rdy_d) begin
      mode_d_r <= mode_c_r;
      flag_d_r <= flag_c_r;
      pr00_d_r <= mul5(m00_c_r, p0_c_r);
      pr01_d_r <= mul5(m01_c_r, p1_c_r);
      pr10_d_r <= mul5(m10_c_r, p0_c_r);
      pr11_d_r <= mul5(m11_c_r, p1_c_r);
    end
  end

  // Stage E: sum, reduce, and force zeros for a decrypt beat whose key has no inverse.
  always_ff @(posedge clk) begin
    if (rdy_e) begin
      mode_e_r <= mode_d_r;
      flag_e_r <= flag_d_r;
      if (flag_d_r) begin
        r0_e_r <= '0;
        r1_e_r <= '0;
      end else begin
        r0_e_r <= mod26(sum_t'(pr00_d_r) + sum_t'(pr01_d_r));
        r1_e_r <= mod26(sum_t'(pr10_d_r) + sum_t'(pr11_d_r));
      end
    end
  end

  // Result beat straight from the last stage.
  assign out_chan.valid              = v_e_r;
  assign out_chan.out_first          = r0_e_r;
  assign out_chan.out_second         = r1_e_r;
  assign out_chan.key_not_invertible = flag_e_r;

`include "hill_cipher_2x2_mod26_top_assert.svh"

  // An accepted beat always occupies the first stage next cycle.
  `HC_ASSERT_NEXT(a_in_lands, in_chan.valid && in_chan.ready, v_a_r)
  // A flagged result carries zeros.
  `HC_ASSERT_NOW(a_flag_zero, v_e_r && flag_e_r, r0_e_r == '0 && r1_e_r == '0)
  // Only a decrypt beat can be flagged.
  `HC_ASSERT_NOW(a_flag_mode, v_e_r && flag_e_r, mode_e_r == MODE_DECRYPT)
  // A waiting result is not dropped from the last stage.
  `HC_ASSERT_NEXT(a_out_kept, v_e_r && !out_chan.ready, v_e_r)

endmodule
